>>> rtl/saee_pkg.sv
// shared constants, codes and types of the supervised automata event engine
package saee_pkg;

  // sizing of the automata bank
  localparam int MAX_PLANTS      = 8;
  localparam int MAX_SUPERVISORS = 8;
  localparam int NUM_STATES      = 16;
  localparam int EVENT_CNT       = 16;
  localparam int NUM_AUT         = MAX_PLANTS + MAX_SUPERVISORS;

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int IDX_W    = 3;
  localparam int STATE_W  = 4;
  localparam int EVENT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 4;
  localparam int PACK_W   = 32;
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int AUT_W    = $clog2(NUM_AUT);
  localparam int SIDX_W   = $clog2(NUM_STATES);
  localparam int EIDX_W   = $clog2(EVENT_CNT);
  localparam int NS_DEPTH = NUM_STATES * EVENT_CNT;
  localparam int NS_AW    = $clog2(NS_DEPTH);
  localparam int PACK_P   = (MAX_PLANTS < 8) ? MAX_PLANTS : 8;
  localparam int PACK_S   = (MAX_SUPERVISORS < 8) ? MAX_SUPERVISORS : 8;

  // command codes
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRIG    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TRIG_SV = 3'd5;

  // result codes
  localparam logic [STATUS_W-1:0] ST_FIRED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BLK_PLANT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BLK_SUP   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLANTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPS   = 1'd1;

  // lane table read request
  typedef struct packed {
    logic               en;
    logic [EVENT_W-1:0] event_id;
    logic [STATE_W-1:0] state;
  } lane_rd_t;

  // lane table write request
  typedef struct packed {
    logic                  en;
    logic [EVENT_W-1:0]    event_id;
    logic [STATE_W-1:0]    state;
    logic [NUM_STATES-1:0] feas;
    logic [STATE_W-1:0]    next;
  } lane_wr_t;

  // next-state table address of a state and an event
  function automatic logic [NS_AW-1:0] ns_addr(input logic [STATE_W-1:0] st,
                                               input logic [EVENT_W-1:0] ev);
    logic [NS_AW+STATE_W-1:0] sum;
    sum = (NS_AW+STATE_W)'(st) * (NS_AW+STATE_W)'(EVENT_CNT) + (NS_AW+STATE_W)'(ev);
    return sum[NS_AW-1:0];
  endfunction

endpackage

>>> rtl/saee_if.sv
// command and result channels of the event engine
interface saee_in_if;
  logic                         valid;
  logic                         ready;
  logic [saee_pkg::MODE_W-1:0]  mode;
  logic                         is_supervisor;
  logic [saee_pkg::IDX_W-1:0]   automaton_index;
  logic [saee_pkg::STATE_W-1:0] from_state;
  logic [saee_pkg::STATE_W-1:0] to_state;
  logic [saee_pkg::EVENT_W-1:0] event_req;

  modport source (output valid, mode, is_supervisor, automaton_index, from_state,
                  to_state, event_req, input ready);
  modport sink (input valid, mode, is_supervisor, automaton_index, from_state,
                to_state, event_req, output ready);
endinterface

interface saee_out_if;
  logic                          valid;
  logic                          ready;
  logic [saee_pkg::STATUS_W-1:0] status;
  logic [saee_pkg::PACK_W-1:0]   plant_states;
  logic [saee_pkg::PACK_W-1:0]   supervisor_states;

  modport source (output valid, status, plant_states, supervisor_states, input ready);
  modport sink (input valid, status, plant_states, supervisor_states, output ready);
endinterface

>>> rtl/saee_lane.sv
// per-automaton transition memories: feasible masks by event and next-state table
module saee_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  saee_pkg::lane_rd_t                rd,
  input  saee_pkg::lane_wr_t                wr,
  output logic [saee_pkg::NUM_STATES-1:0]   feas,
  output logic [saee_pkg::STATE_W-1:0]      next_state
);

  logic [saee_pkg::NUM_STATES-1:0] feas_mem [saee_pkg::EVENT_CNT];
  logic [saee_pkg::STATE_W-1:0]    ns_mem   [saee_pkg::NS_DEPTH];
  logic [saee_pkg::EVENT_CNT-1:0]  vld_r;
  logic [saee_pkg::NUM_STATES-1:0] feas_q_r;
  logic                            vld_q_r;
  logic [saee_pkg::STATE_W-1:0]    ns_q_r;

  // valid bits stand in for clearing the feasible masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.event_id[saee_pkg::EIDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      feas_mem[wr.event_id[saee_pkg::EIDX_W-1:0]] <= wr.feas;
      ns_mem[saee_pkg::ns_addr(wr.state, wr.event_id)] <= wr.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      feas_q_r <= feas_mem[rd.event_id[saee_pkg::EIDX_W-1:0]];
      vld_q_r  <= vld_r[rd.event_id[saee_pkg::EIDX_W-1:0]];
      ns_q_r   <= ns_mem[saee_pkg::ns_addr(rd.state, rd.event_id)];
    end
  end

  assign feas       = vld_q_r ? feas_q_r : '0;
  assign next_state = ns_q_r;

endmodule

>>> rtl/supervised_automata_event_engine.sv
// top level: command decode, trigger checks and state write-back of the event engine
//
// usage
// - in_ch carries one command item: load a transition, set a state, disable or
//   enable an event in a supervisor, or trigger an event (checked or supervisors only)
// - out_ch returns exactly one item per command: a status code and the current
//   states of all plants and supervisors, four bits each, after the command
// - cfg_we/cfg_index/cfg_wdata write plants_in_use (index 0) and
//   supervisors_in_use (index 1); values above the bank size saturate
// - each automaton owns a lane of memories; every lane reads its tables at the
//   edge the item is accepted, then evaluates and writes back in the exec state
//   once the output register is free
// - a new command is accepted only in the idle state, after the previous one has
//   been evaluated and written back
// - a result waiting in the output register does not block acceptance; a second
//   result is held in the evaluate stage until the receiver takes the first
// - reset (rst_n low, synchronous) zeroes all states, masks, the configuration and the
//   control registers; no clearing pass is needed, the block is ready right after reset
module supervised_automata_event_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  saee_in_if.sink                          in_ch,
  saee_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [saee_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [saee_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;

  // configuration
  logic [saee_pkg::CNT_W-1:0] plants_in_use_r;
  logic [saee_pkg::CNT_W-1:0] supervisors_in_use_r;

  // captured command
  logic [saee_pkg::MODE_W-1:0]  mode_r;
  logic                         is_sup_r;
  logic [saee_pkg::IDX_W-1:0]   idx_r;
  logic [saee_pkg::STATE_W-1:0] from_r;
  logic [saee_pkg::STATE_W-1:0] to_r;
  logic [saee_pkg::EVENT_W-1:0] ev_r;

  // automaton states and supervisor masks
  logic [saee_pkg::STATE_W-1:0]   cur_r   [saee_pkg::NUM_AUT];
  logic [saee_pkg::STATE_W-1:0]   cur_nxt [saee_pkg::NUM_AUT];
  logic [saee_pkg::EVENT_CNT-1:0] dis_r   [saee_pkg::MAX_SUPERVISORS];
  logic [saee_pkg::EVENT_CNT-1:0] dis_nxt [saee_pkg::MAX_SUPERVISORS];

  // lane interface
  saee_pkg::lane_rd_t              lane_rd [saee_pkg::NUM_AUT];
  saee_pkg::lane_wr_t              lane_wr [saee_pkg::NUM_AUT];
  logic [saee_pkg::NUM_STATES-1:0] feas    [saee_pkg::NUM_AUT];
  logic [saee_pkg::STATE_W-1:0]    ns_data [saee_pkg::NUM_AUT];

  // output register
  logic                          out_valid_r;
  logic [saee_pkg::STATUS_W-1:0] out_status_r;
  logic [saee_pkg::PACK_W-1:0]   out_plant_r;
  logic [saee_pkg::PACK_W-1:0]   out_sup_r;

  logic in_fire;
  logic exec_fire;
  logic [saee_pkg::CNT_W-1:0]   np;
  logic [saee_pkg::CNT_W-1:0]   ns;
  logic [saee_pkg::AUT_W-1:0]   a_sel;
  logic                         idx_ok;
  logic                         ev_ok;
  logic                         from_ok;
  logic                         to_ok;
  logic                         load_wr;
  logic                         plant_blk;
  logic                         sup_blk;
  logic [saee_pkg::NUM_AUT-1:0] in_use;
  logic [saee_pkg::NUM_AUT-1:0] move;
  logic [saee_pkg::NUM_STATES-1:0] feas_sel;
  logic [saee_pkg::NUM_STATES-1:0] feas_wdata;
  logic [saee_pkg::STATUS_W-1:0]   status_nxt;
  logic [saee_pkg::PACK_W-1:0]     plant_pack;
  logic [saee_pkg::PACK_W-1:0]     sup_pack;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer: accept, then evaluate once the output slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) state_r <= S_EXEC;
        S_EXEC: if (exec_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plants_in_use_r      <= '0;
      supervisors_in_use_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        saee_pkg::CFG_PLANTS: plants_in_use_r      <= cfg_wdata;
        saee_pkg::CFG_SUPS:   supervisors_in_use_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= in_ch.mode;
      is_sup_r <= in_ch.is_supervisor;
      idx_r    <= in_ch.automaton_index;
      from_r   <= in_ch.from_state;
      to_r     <= in_ch.to_state;
      ev_r     <= in_ch.event_req;
    end
  end

  // saturated counts of automata taking part
  assign np = (int'(plants_in_use_r) > saee_pkg::MAX_PLANTS) ?
              saee_pkg::CNT_W'(saee_pkg::MAX_PLANTS) : plants_in_use_r;
  assign ns = (int'(supervisors_in_use_r) > saee_pkg::MAX_SUPERVISORS) ?
              saee_pkg::CNT_W'(saee_pkg::MAX_SUPERVISORS) : supervisors_in_use_r;

  assign idx_ok  = is_sup_r ? (int'(idx_r) < saee_pkg::MAX_SUPERVISORS)
                            : (int'(idx_r) < saee_pkg::MAX_PLANTS);
  assign a_sel   = is_sup_r ? saee_pkg::AUT_W'(saee_pkg::MAX_PLANTS + int'(idx_r))
                            : saee_pkg::AUT_W'(idx_r);
  assign ev_ok   = int'(ev_r) < saee_pkg::EVENT_CNT;
  assign from_ok = int'(from_r) < saee_pkg::NUM_STATES;
  assign to_ok   = int'(to_r) < saee_pkg::NUM_STATES;

  // lanes: plants first, then supervisors
  for (genvar l = 0; l < saee_pkg::NUM_AUT; l++) begin : g_lane
    always_comb begin
      lane_rd[l].en       = in_fire;
      lane_rd[l].event_id = in_ch.event_req;
      lane_rd[l].state    = cur_r[l];
      lane_wr[l].en       = exec_fire && load_wr && (a_sel == saee_pkg::AUT_W'(l));
      lane_wr[l].event_id = ev_r;
      lane_wr[l].state    = from_r;
      lane_wr[l].feas     = feas_wdata;
      lane_wr[l].next     = to_r;
    end

    saee_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .rd         (lane_rd[l]),
      .wr         (lane_wr[l]),
      .feas       (feas[l]),
      .next_state (ns_data[l])
    );
  end

  // load keeps the first transition for a state and event
  assign feas_sel   = feas[a_sel];
  assign feas_wdata = feas_sel | (saee_pkg::NUM_STATES'(1) << from_r[saee_pkg::SIDX_W-1:0]);
  assign load_wr    = (mode_r == saee_pkg::MODE_LOAD) && idx_ok && ev_ok && from_ok && to_ok
                      && !feas_sel[from_r[saee_pkg::SIDX_W-1:0]];

  // trigger checks over the lanes
  always_comb begin
    plant_blk = 1'b0;
    sup_blk   = 1'b0;
    for (int l = 0; l < saee_pkg::NUM_AUT; l++) begin
      if (l < saee_pkg::MAX_PLANTS) begin
        in_use[l] = l < int'(np);
      end else begin
        in_use[l] = (l - saee_pkg::MAX_PLANTS) < int'(ns);
      end
      move[l] = feas[l][cur_r[l][saee_pkg::SIDX_W-1:0]];
      if (l < saee_pkg::MAX_PLANTS && in_use[l] && (|feas[l]) && !move[l]) begin
        plant_blk = 1'b1;
      end
    end
    for (int s = 0; s < saee_pkg::MAX_SUPERVISORS; s++) begin
      if (s < int'(ns) && dis_r[s][ev_r[saee_pkg::EIDX_W-1:0]]) begin
        sup_blk = 1'b1;
      end
    end
  end

  // command execution: status, next states and masks
  always_comb begin
    status_nxt = saee_pkg::ST_DONE;
    for (int l = 0; l < saee_pkg::NUM_AUT; l++) begin
      cur_nxt[l] = cur_r[l];
    end
    for (int s = 0; s < saee_pkg::MAX_SUPERVISORS; s++) begin
      dis_nxt[s] = dis_r[s];
    end
    case (mode_r)
      saee_pkg::MODE_SET: begin
        if (idx_ok && to_ok) cur_nxt[a_sel] = to_r;
      end
      saee_pkg::MODE_DISABLE: begin
        if (is_sup_r && idx_ok && ev_ok) begin
          dis_nxt[idx_r][ev_r[saee_pkg::EIDX_W-1:0]] = 1'b1;
        end
      end
      saee_pkg::MODE_ENABLE: begin
        if (is_sup_r && idx_ok && ev_ok) begin
          dis_nxt[idx_r][ev_r[saee_pkg::EIDX_W-1:0]] = 1'b0;
        end
      end
      saee_pkg::MODE_TRIG: begin
        status_nxt = saee_pkg::ST_FIRED;
        if (ev_ok) begin
          if (plant_blk) begin
            status_nxt = saee_pkg::ST_BLK_PLANT;
          end else if (sup_blk) begin
            status_nxt = saee_pkg::ST_BLK_SUP;
          end else begin
            for (int l = 0; l < saee_pkg::NUM_AUT; l++) begin
              if (in_use[l] && move[l]) cur_nxt[l] = ns_data[l];
            end
          end
        end
      end
      saee_pkg::MODE_TRIG_SV: begin
        status_nxt = saee_pkg::ST_FIRED;
        if (ev_ok) begin
          for (int l = saee_pkg::MAX_PLANTS; l < saee_pkg::NUM_AUT; l++) begin
            if (in_use[l] && move[l]) cur_nxt[l] = ns_data[l];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < saee_pkg::NUM_AUT; l++) cur_r[l] <= '0;
      for (int s = 0; s < saee_pkg::MAX_SUPERVISORS; s++) dis_r[s] <= '0;
    end else if (exec_fire) begin
      for (int l = 0; l < saee_pkg::NUM_AUT; l++) cur_r[l] <= cur_nxt[l];
      for (int s = 0; s < saee_pkg::MAX_SUPERVISORS; s++) dis_r[s] <= dis_nxt[s];
    end
  end

  // state snapshot after the command
  always_comb begin
    plant_pack = '0;
    sup_pack   = '0;
    for (int i = 0; i < saee_pkg::PACK_P; i++) begin
      plant_pack[i*saee_pkg::STATE_W +: saee_pkg::STATE_W] = cur_nxt[i];
    end
    for (int i = 0; i < saee_pkg::PACK_S; i++) begin
      sup_pack[i*saee_pkg::STATE_W +: saee_pkg::STATE_W] = cur_nxt[saee_pkg::MAX_PLANTS + i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r <= status_nxt;
      out_plant_r  <= plant_pack;
      out_sup_r    <= sup_pack;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.plant_states      = out_plant_r;
  assign out_ch.supervisor_states = out_sup_r;

endmodule
